/* hdl/dgt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dgt_pkg
// Shared types and constants of the depth grid triangulator.
// ----------------------------------------------------------------------------
package dgt_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_DEPTH_BITS = 16;

    localparam int IDX_W   = 20;          // vertex index width
    localparam int ENTRY_W = IDX_W + 1;   // valid bit on top of the index
    localparam int CFG_AW  = 8;
    localparam int CFG_DW  = 16;
    localparam int DIM_W   = 11;
    localparam int COORD_W = 10;
    localparam int VDEP_W  = 16;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_MIN_DEPTH    = 8'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_DEPTH    = 8'd1;
    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 8'd2;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 8'd3;

    localparam logic [15:0]      RST_MIN_DEPTH    = 16'd0;
    localparam logic [15:0]      RST_MAX_DEPTH    = 16'd65535;
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    // record kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_FACE   = 1'b1;

    localparam logic [ENTRY_W-1:0] BAD_MARK = '0;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } face_t;

    typedef struct packed {
        logic [1:0] count;
        face_t      f0;
        face_t      f1;
    } faces_t;

endpackage
`default_nettype wire

/* hdl/depth_grid_triangulator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// depth_grid_triangulator
// Turns a raster stream of depth samples into vertex and triangle records.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_depth
//   m_       out        m_valid / m_ready    kind, row, col, depth, index,
//                                            corners a/b/c, last
//   cfg_     in         cfg_valid/cfg_ready  cfg_addr, cfg_data
//
// A sample is latched with its line buffer read, then resolved into up to
// three records held in the output register.
// Throughput: one sample per cycle while each makes at most one record and
// the output is ready; a sample with more records (at most 3) stalls the input.
// Synchronous active-low reset clears counters, quad history and the
// pipeline; line buffer contents are not cleared. Config is always ready.
// ----------------------------------------------------------------------------
module depth_grid_triangulator #(
    parameter int MAX_WIDTH  = dgt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dgt_pkg::DEF_MAX_HEIGHT,
    parameter int DEPTH_BITS = dgt_pkg::DEF_DEPTH_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [DEPTH_BITS-1:0]        s_depth,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_kind,
    output logic [dgt_pkg::COORD_W-1:0]       m_row,
    output logic [dgt_pkg::COORD_W-1:0]       m_col,
    output logic [dgt_pkg::VDEP_W-1:0]        m_vertex_depth,
    output logic [dgt_pkg::IDX_W-1:0]         m_vertex_index,
    output logic [dgt_pkg::IDX_W-1:0]         m_corner_a,
    output logic [dgt_pkg::IDX_W-1:0]         m_corner_b,
    output logic [dgt_pkg::IDX_W-1:0]         m_corner_c,
    output logic                              m_last,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [dgt_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [dgt_pkg::CFG_DW-1:0]   cfg_data
);
    import dgt_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CW    = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int RW    = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;
    localparam int DW    = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;

    // configuration
    logic [15:0]      min_depth_reg, max_depth_reg;
    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;

    // raster counters
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;
    logic             col_wrap, row_wrap;

    // resolve stage
    logic                  st_valid_reg, st_valid_next;
    logic [DEPTH_BITS-1:0] st_depth_reg;
    logic [COL_W-1:0]      st_col_reg;
    logic [ROW_W-1:0]      st_row_reg;
    logic                  st_quad_reg;
    logic                  st_frame_end_reg;
    logic                  fwd_reg;
    logic [ENTRY_W-1:0]    fwd_data_reg;

    logic [ENTRY_W-1:0]    left_reg, top_left_reg;
    logic [IDX_W-1:0]      vcount_reg, vcount_next;

    logic                  accept, commit;
    logic [ENTRY_W-1:0]    ram_rdata, tr, br;
    logic                  vtx_ok;
    logic [DW-1:0]         d_ext, min_ext, max_ext;
    faces_t                faces;

    // output register
    logic [2:0]            pend_reg, pend_next, pend_after, head;
    logic                  out_pop, out_free;
    logic [ROW_W-1:0]      o_row_reg;
    logic [COL_W-1:0]      o_col_reg;
    logic [VDEP_W-1:0]     o_depth_reg;
    logic [IDX_W-1:0]      o_index_reg;
    face_t                 o_f0_reg, o_f1_reg;
    logic [ROW_W+COORD_W-1:0]     row_ext;
    logic [COL_W+COORD_W-1:0]     col_ext;
    logic [DEPTH_BITS+VDEP_W-1:0] dep_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_depth_reg    <= RST_MIN_DEPTH;
            max_depth_reg    <= RST_MAX_DEPTH;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_MIN_DEPTH:    min_depth_reg    <= cfg_data;
                REG_MAX_DEPTH:    max_depth_reg    <= cfg_data;
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = CW'(1);
        end else if (CW'(frame_width_reg) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = RW'(1);
        end else if (RW'(frame_height_reg) > RW'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(frame_height_reg);
        end
    end

    assign col_wrap = (CW'(col_count_reg) + CW'(1)) >= w_eff;
    assign row_wrap = (RW'(row_count_reg) + RW'(1)) >= h_eff;

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept) begin
            if (col_wrap) begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : row_count_reg + ROW_W'(1);
            end else begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    assign accept        = s_valid && s_ready;
    assign s_ready       = !st_valid_reg || commit;
    assign commit        = st_valid_reg && out_free;
    assign st_valid_next = accept ? 1'b1 : (commit ? 1'b0 : st_valid_reg);

    dgt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (st_col_reg),
        .wr_data (br),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            st_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            st_valid_reg  <= st_valid_next;
            if (accept) begin
                // same column written in this cycle: RAM returns stale data
                fwd_reg <= commit && (st_col_reg == col_count_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_depth_reg     <= s_depth;
            st_col_reg       <= col_count_reg;
            st_row_reg       <= row_count_reg;
            st_quad_reg      <= (row_count_reg != '0) && (col_count_reg != '0);
            st_frame_end_reg <= col_wrap && row_wrap;
            fwd_data_reg     <= br;
        end
    end

    assign d_ext   = DW'(st_depth_reg);
    assign min_ext = DW'(min_depth_reg);
    assign max_ext = DW'(max_depth_reg);
    assign vtx_ok  = (d_ext >= min_ext) && (d_ext <= max_ext);
    assign br      = vtx_ok ? {1'b1, vcount_reg} : BAD_MARK;
    assign tr      = fwd_reg ? fwd_data_reg : ram_rdata;

    dgt_quad u_quad (
        .en    (st_quad_reg),
        .tl    (top_left_reg),
        .tr    (tr),
        .bl    (left_reg),
        .br    (br),
        .faces (faces)
    );

    always_comb begin
        vcount_next = vcount_reg;
        if (commit) begin
            if (st_frame_end_reg) begin
                vcount_next = '0;
            end else if (vtx_ok) begin
                vcount_next = vcount_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= BAD_MARK;
            top_left_reg <= BAD_MARK;
            vcount_reg   <= '0;
        end else begin
            vcount_reg <= vcount_next;
            if (commit) begin
                left_reg     <= br;
                top_left_reg <= tr;
            end
        end
    end

    // pend bits: vertex, first face, second face; lowest set bit goes first
    assign head       = pend_reg & (~pend_reg + 3'd1);
    assign out_pop    = m_valid && m_ready;
    assign pend_after = out_pop ? (pend_reg & ~head) : pend_reg;
    assign out_free   = (pend_after == 3'b000);

    always_comb begin
        pend_next = pend_after;
        if (commit) begin
            pend_next = {faces.count == 2'd2, faces.count != 2'd0, vtx_ok};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'b000;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            o_row_reg   <= st_row_reg;
            o_col_reg   <= st_col_reg;
            o_depth_reg <= dep_ext[VDEP_W-1:0];
            o_index_reg <= vcount_reg;
            o_f0_reg    <= faces.f0;
            o_f1_reg    <= faces.f1;
        end
    end

    assign dep_ext = {{VDEP_W{1'b0}}, st_depth_reg};
    assign row_ext = {{COORD_W{1'b0}}, o_row_reg};
    assign col_ext = {{COORD_W{1'b0}}, o_col_reg};

    assign m_valid = (pend_reg != 3'b000);
    assign m_last  = ((pend_reg & ~head) == 3'b000);

    always_comb begin
        m_kind         = KIND_FACE;
        m_row          = '0;
        m_col          = '0;
        m_vertex_depth = '0;
        m_vertex_index = '0;
        m_corner_a     = '0;
        m_corner_b     = '0;
        m_corner_c     = '0;
        if (head[0]) begin
            m_kind         = KIND_VERTEX;
            m_row          = row_ext[COORD_W-1:0];
            m_col          = col_ext[COORD_W-1:0];
            m_vertex_depth = o_depth_reg;
            m_vertex_index = o_index_reg;
        end else if (head[1]) begin
            m_corner_a = o_f0_reg.a;
            m_corner_b = o_f0_reg.b;
            m_corner_c = o_f0_reg.c;
        end else begin
            m_corner_a = o_f1_reg.a;
            m_corner_b = o_f1_reg.b;
            m_corner_c = o_f1_reg.c;
        end
    end

endmodule
`default_nettype wire

/* hdl/dgt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dgt_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dgt_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* hdl/dgt_quad.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dgt_quad
// Classifies one 2x2 quad of vertex entries and forms its triangles.
// ----------------------------------------------------------------------------
module dgt_quad (
    input  wire logic                          en,
    input  wire logic [dgt_pkg::ENTRY_W-1:0]   tl,
    input  wire logic [dgt_pkg::ENTRY_W-1:0]   tr,
    input  wire logic [dgt_pkg::ENTRY_W-1:0]   bl,
    input  wire logic [dgt_pkg::ENTRY_W-1:0]   br,
    output dgt_pkg::faces_t                    faces
);
    import dgt_pkg::*;

    logic             vtl, vtr, vbl, vbr;
    logic [2:0]       bad_cnt;
    logic [IDX_W-1:0] itl, itr, ibl, ibr;

    assign vtl = tl[ENTRY_W-1];
    assign vtr = tr[ENTRY_W-1];
    assign vbl = bl[ENTRY_W-1];
    assign vbr = br[ENTRY_W-1];
    assign itl = tl[IDX_W-1:0];
    assign itr = tr[IDX_W-1:0];
    assign ibl = bl[IDX_W-1:0];
    assign ibr = br[IDX_W-1:0];

    assign bad_cnt = {2'b00, ~vtl} + {2'b00, ~vtr} + {2'b00, ~vbl} + {2'b00, ~vbr};

    always_comb begin
        faces.count = 2'd0;
        faces.f0    = '{a: itl, b: itr, c: ibr};
        faces.f1    = '{a: itl, b: ibl, c: ibr};
        if (en) begin
            case (bad_cnt)
                3'd0: begin
                    faces.count = 2'd2;
                end
                3'd1: begin
                    faces.count = 2'd1;
                    // the three good corners, kept in tl, tr, bl, br order
                    if (!vtl) begin
                        faces.f0 = '{a: itr, b: ibl, c: ibr};
                    end else if (!vtr) begin
                        faces.f0 = '{a: itl, b: ibl, c: ibr};
                    end else if (!vbl) begin
                        faces.f0 = '{a: itl, b: itr, c: ibr};
                    end else begin
                        faces.f0 = '{a: itl, b: itr, c: ibl};
                    end
                end
                default: begin
                    faces.count = 2'd0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* verif/depth_grid_triangulator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_grid_triangulator_tb
// Self-checking bench for the depth grid triangulator. Raster depth samples
// are pushed in, and every vertex and triangle record that comes out is
// matched in order against a behavioral model of vertex numbering and 2x2
// quad classification kept in this file. Both handshakes idle at random,
// the depth window and frame geometry change between phases, and the output
// is held off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module depth_grid_triangulator_tb;
    import dgt_pkg::*;

    localparam int MAX_W            = DEF_MAX_WIDTH;
    localparam int MAX_H            = DEF_MAX_HEIGHT;
    localparam int DRAIN_CYCLES     = 12;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_ITEMS     = 450;
    localparam int SETTLE_LIMIT     = 20000;

    typedef logic [DEF_DEPTH_BITS-1:0] depth_t;
    typedef logic [ENTRY_W-1:0]        entry_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VDEP_W-1:0]  vdepth;
        logic [IDX_W-1:0]   vindex;
        logic [IDX_W-1:0]   a;
        logic [IDX_W-1:0]   b;
        logic [IDX_W-1:0]   c;
        logic               last;
    } rec_t;

    typedef enum logic {STEP_CFG, STEP_SAMPLE} step_kind_t;

    typedef struct {
        step_kind_t        step;
        logic [CFG_AW-1:0] addr;
        logic [CFG_DW-1:0] value;   // register data or depth sample
        bit                typed;
        rec_t              want;
    } script_row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    depth_t              s_depth   = '0;
    logic                m_ready   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr  = '0;
    logic [CFG_DW-1:0]   cfg_data  = '0;

    logic                s_ready;
    logic                m_valid;
    logic                m_kind;
    logic [COORD_W-1:0]  m_row;
    logic [COORD_W-1:0]  m_col;
    logic [VDEP_W-1:0]   m_vertex_depth;
    logic [IDX_W-1:0]    m_vertex_index;
    logic [IDX_W-1:0]    m_corner_a;
    logic [IDX_W-1:0]    m_corner_b;
    logic [IDX_W-1:0]    m_corner_c;
    logic                m_last;
    logic                cfg_ready;

    always #1 aclk = ~aclk;

    depth_grid_triangulator u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_depth        (s_depth),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_row          (m_row),
        .m_col          (m_col),
        .m_vertex_depth (m_vertex_depth),
        .m_vertex_index (m_vertex_index),
        .m_corner_a     (m_corner_a),
        .m_corner_b     (m_corner_b),
        .m_corner_c     (m_corner_c),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data)
    );

    // mesh model state
    entry_t             line_idx [MAX_W];
    bit                 line_written [MAX_W];
    int                 line_prefix;      // columns 0..line_prefix-1 hold real entries
    entry_t             left_idx;
    entry_t             corner_idx;       // top-left of the next quad
    logic [IDX_W-1:0]   vert_cnt;
    int                 row_cnt;
    int                 col_cnt;
    logic [15:0]        min_d;
    logic [15:0]        max_d;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    rec_t               step_recs [3];

    rec_t               expected_records [$];
    script_row_t        script [$];

    bit                 src_calm;
    bit                 dst_calm;
    bit                 hold_req;
    int                 holds_done;
    int                 samples_sent;
    int                 directed_samples;
    int                 phases_run;
    int                 vertices_seen;
    int                 faces_seen;
    int                 mismatches;

    function automatic int eff_dim(logic [DIM_W-1:0] v, int hi);
        if (v == 0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic rec_t face_rec(entry_t a, entry_t b, entry_t c);
        rec_t r;
        r      = '0;
        r.kind = KIND_FACE;
        r.a    = a[IDX_W-1:0];
        r.b    = b[IDX_W-1:0];
        r.c    = c[IDX_W-1:0];
        return r;
    endfunction

    function automatic rec_t vertex_rec(int row, int col, depth_t d, int idx);
        rec_t r;
        r        = '0;
        r.kind   = KIND_VERTEX;
        r.row    = COORD_W'(row);
        r.col    = COORD_W'(col);
        r.vdepth = d;
        r.vindex = IDX_W'(idx);
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic void reset_model();
        foreach (line_idx[i]) begin
            line_idx[i]     = BAD_MARK;
            line_written[i] = 1'b0;
        end
        line_prefix = 0;
        left_idx    = BAD_MARK;
        corner_idx  = BAD_MARK;
        vert_cnt    = '0;
        row_cnt     = 0;
        col_cnt     = 0;
        min_d       = RST_MIN_DEPTH;
        max_d       = RST_MAX_DEPTH;
        width_reg   = RST_FRAME_WIDTH;
        height_reg  = RST_FRAME_HEIGHT;
    endfunction

    // Advances the mesh state by one pixel; fills step_recs, returns the count.
    function automatic int triangulate_sample(depth_t d);
        int     n;
        int     w;
        int     h;
        entry_t tl;
        entry_t tr;
        entry_t bl;
        entry_t br;
        n  = 0;
        w  = eff_dim(width_reg, MAX_W);
        h  = eff_dim(height_reg, MAX_H);
        br = BAD_MARK;
        if (d >= min_d && d <= max_d) begin
            br           = {1'b1, vert_cnt};
            step_recs[0] = vertex_rec(row_cnt, col_cnt, d, int'(vert_cnt));
            step_recs[0].last = 1'b0;
            n            = 1;
            vert_cnt     = vert_cnt + 1'b1;
        end
        tl = corner_idx;
        tr = line_idx[col_cnt];
        bl = left_idx;
        if (row_cnt > 0 && col_cnt > 0) begin
            case ($countones({~tl[IDX_W], ~tr[IDX_W], ~bl[IDX_W], ~br[IDX_W]}))
                0: begin
                    step_recs[n]     = face_rec(tl, tr, br);
                    step_recs[n + 1] = face_rec(tl, bl, br);
                    n += 2;
                end
                1: begin
                    if (!tl[IDX_W]) step_recs[n] = face_rec(tr, bl, br);
                    else if (!tr[IDX_W]) step_recs[n] = face_rec(tl, bl, br);
                    else if (!bl[IDX_W]) step_recs[n] = face_rec(tl, tr, br);
                    else step_recs[n] = face_rec(tl, tr, bl);
                    n += 1;
                end
                default: ;
            endcase
        end
        corner_idx            = tr;
        left_idx              = br;
        line_idx[col_cnt]     = br;
        line_written[col_cnt] = 1'b1;
        while (line_prefix < MAX_W && line_written[line_prefix]) line_prefix++;
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            if (row_cnt + 1 >= h) begin
                row_cnt  = 0;
                vert_cnt = '0;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
        if (n > 0) step_recs[n - 1].last = 1'b1;
        return n;
    endfunction

    function automatic void reg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] v);
        script.push_back('{STEP_CFG, addr, v, 1'b0, '0});
    endfunction

    function automatic void sample(depth_t d);
        script.push_back('{STEP_SAMPLE, '0, d, 1'b0, '0});
    endfunction

    function automatic void sample_is(depth_t d, int row, int col, int idx);
        script.push_back('{STEP_SAMPLE, '0, d, 1'b1, vertex_rec(row, col, d, idx)});
    endfunction

    function automatic void build_script();
        // reset geometry 640x480, full depth window
        sample_is(16'd0, 0, 0, 0);
        sample_is(16'hFFFF, 0, 1, 1);
        sample(16'h5555);
        sample(16'hAAAA);
        // shrink to 3x3 with column 4 next: the column counter wraps on the next pixel
        reg_write(REG_MIN_DEPTH, 16'd100);
        reg_write(REG_MAX_DEPTH, 16'd200);
        reg_write(REG_FRAME_WIDTH, 16'd3);
        reg_write(REG_FRAME_HEIGHT, 16'd3);
        sample(16'd99);
        sample(16'd100);
        sample(16'd200);
        sample(16'd201);
        sample(16'd150);
        sample(16'd0);
        sample(16'd150);
        // next frame: bad top-left corner, then full quad
        sample(16'hFFFF);
        sample(16'd150);
        sample(16'd150);
        sample(16'd150);
        sample(16'd150);
        sample(16'd150);
        // empty depth window
        reg_write(REG_MIN_DEPTH, 16'd300);
        reg_write(REG_MAX_DEPTH, 16'd200);
        sample(16'd0);
        sample(16'd250);
        sample(16'hFFFF);
        // zero geometry acts as 1x1, every pixel closes a frame
        reg_write(REG_MIN_DEPTH, 16'd0);
        reg_write(REG_MAX_DEPTH, 16'hFFFF);
        reg_write(REG_FRAME_WIDTH, 16'd0);
        reg_write(REG_FRAME_HEIGHT, 16'd0);
        sample_is(16'd7, 0, 0, 0);
        sample_is(16'hFFFF, 0, 0, 0);
        sample_is(16'd0, 0, 0, 0);
    endfunction

    function automatic depth_t pick_depth();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2: return min_d;
            3: return max_d;
            4: return min_d - 1'b1;
            5: return max_d + 1'b1;
            6, 7, 8: return depth_t'($urandom_range(0, 65535));
            default: begin
                if (min_d <= max_d) return depth_t'($urandom_range(min_d, max_d));
                return depth_t'($urandom());
            end
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(int small_max);
        case ($urandom_range(0, 19))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd1024;
            3: return 11'd2047;
            default: return DIM_W'($urandom_range(2, small_max));
        endcase
    endfunction

    // Block is idle once every expected record is back and the pipe has drained.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_records.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (addr)
            REG_MIN_DEPTH:    min_d      = data;
            REG_MAX_DEPTH:    max_d      = data;
            REG_FRAME_WIDTH:  width_reg  = data[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(depth_t d, bit typed, rec_t want);
        int gap;
        int n;
        gap = src_calm ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_depth <= d;
        do @(posedge aclk); while (!s_ready);
        n = triangulate_sample(d);
        if (typed) begin
            expected_records.push_back(want);
        end else begin
            for (int i = 0; i < n; i++) expected_records.push_back(step_recs[i]);
        end
        samples_sent++;
    endtask

    task automatic run_phase(int n_items, bit wide, bit squeeze);
        logic [15:0]      lo;
        logic [15:0]      hi;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        case ($urandom_range(0, 9))
            0: begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            1: begin
                lo = 16'($urandom_range(1, 65535));
                hi = 16'($urandom_range(0, lo - 1));
            end
            default: begin
                lo = 16'($urandom_range(0, 30000));
                hi = 16'($urandom_range(lo, 65535));
            end
        endcase
        w = pick_dim(9);
        h = pick_dim(6);
        if (wide) begin
            w = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
            h = 11'd2047;
        end
        // past row 0, only widen over line buffer columns already filled
        if (row_cnt != 0 && eff_dim(w, MAX_W) > line_prefix) w = DIM_W'(line_prefix);
        cfg_write(REG_MIN_DEPTH, lo);
        cfg_write(REG_MAX_DEPTH, hi);
        cfg_write(REG_FRAME_WIDTH, CFG_DW'(w));
        cfg_write(REG_FRAME_HEIGHT, CFG_DW'(h));
        src_calm = ($urandom_range(0, 3) == 0) || squeeze;
        dst_calm = ($urandom_range(0, 3) == 0);
        if (squeeze) hold_req = 1'b1;
        repeat (n_items) send_sample(pick_depth(), 1'b0, '0);
        phases_run++;
    endtask

    function automatic bit field_bad(string name, longint unsigned want, longint unsigned got);
        if (want == got) return 1'b0;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1'b1;
    endfunction

    // output side: random stall per record, one long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = dst_calm ? 0 : $urandom_range(0, 15);
            if (hold_req) begin
                gap += HOLD_CYCLES;
                hold_req = 1'b0;
                holds_done++;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        rec_t want;
        bit   bad;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $error("record transfer with nothing expected (kind %0d)", m_kind);
                mismatches++;
            end else begin
                want = expected_records.pop_front();
                bad  = 1'b0;
                bad |= field_bad("kind", want.kind, m_kind);
                bad |= field_bad("row", want.row, m_row);
                bad |= field_bad("col", want.col, m_col);
                bad |= field_bad("vertex_depth", want.vdepth, m_vertex_depth);
                bad |= field_bad("vertex_index", want.vindex, m_vertex_index);
                bad |= field_bad("corner_a", want.a, m_corner_a);
                bad |= field_bad("corner_b", want.b, m_corner_b);
                bad |= field_bad("corner_c", want.c, m_corner_c);
                bad |= field_bad("last", want.last, m_last);
                if (bad) mismatches++;
                if (want.kind == KIND_VERTEX) vertices_seen++;
                else faces_seen++;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int random_sent;
        int n_items;
        random_sent = 0;
        reset_model();
        build_script();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].step == STEP_CFG) begin
                cfg_write(script[i].addr, script[i].value);
            end else begin
                send_sample(script[i].value, script[i].typed, script[i].want);
                directed_samples++;
            end
        end

        // first phase hits saturated geometry, second one backs up the input
        while (random_sent < RANDOM_ITEMS) begin
            n_items = $urandom_range(20, 60);
            run_phase(n_items, phases_run == 0, phases_run == 1);
            random_sent += n_items;
        end

        settle();
        if (expected_records.size() != 0) begin
            $error("%0d expected records never arrived", expected_records.size());
            mismatches++;
        end
        $display("covered %0d directed and %0d random samples over %0d depth/geometry settings",
                 directed_samples, random_sent, phases_run);
        $display("checked %0d vertex and %0d triangle records, %0d long output hold-offs",
                 vertices_seen, faces_seen, holds_done);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
